### src/ccs_pkg.sv
// Shared constants, types and filter step functions for the comment and splice stripper.
`default_nettype none
package ccs_pkg;

	// Character codes the filters look for
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;

	// Result slots that one item can fill (final item flushes three holds)
	localparam int unsigned SLOTS = 4;
	localparam int unsigned SLOT_W = $clog2(SLOTS);

	// Default depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// State of the three filters, plus the byte that the last push emitted
	typedef struct packed {
		logic [7:0] splice_b;
		logic       splice_v;
		logic [7:0] block_b;
		logic       block_v;
		logic       in_block;
		logic [7:0] line_b;
		logic       line_v;
		logic       in_line;
		logic       emit_v;
		logic [7:0] emit_b;
	} filt_t;

	// One queued item: up to four result bytes, which of them exist, and end of text
	typedef struct packed {
		logic                  fin;
		logic [SLOTS-1:0]      mask;
		logic [SLOTS-1:0][7:0] bytes;
	} qent_t;

	// Head of the queue as seen by the back end
	typedef struct packed {
		logic  valid;
		qent_t ent;
	} qhead_t;

	// Line comment filter: drops from double slash up to, not including, newline
	function automatic filt_t line_push(filt_t s_in, logic [7:0] c);
		filt_t s;
		s = s_in;
		s.emit_v = 1'b0;
		s.emit_b = 8'h00;
		if (s.in_line) begin
			if (c == CH_NEWLINE) begin
				s.in_line = 1'b0;
				s.line_b  = c;
				s.line_v  = 1'b1;
			end
		end else if (s.line_v && s.line_b == CH_SLASH && c == CH_SLASH) begin
			s.in_line = 1'b1;
			s.line_v  = 1'b0;
			s.line_b  = 8'h00;
		end else begin
			if (s.line_v) begin
				s.emit_v = 1'b1;
				s.emit_b = s.line_b;
			end
			s.line_b = c;
			s.line_v = 1'b1;
		end
		return s;
	endfunction

	// Block comment filter: drops slash-star through star-slash, no nesting
	function automatic filt_t block_push(filt_t s_in, logic [7:0] c);
		filt_t s;
		s = s_in;
		s.emit_v = 1'b0;
		s.emit_b = 8'h00;
		if (s.block_v && s.in_block && s.block_b == CH_STAR && c == CH_SLASH) begin
			s.in_block = 1'b0;
			s.block_v  = 1'b0;
			s.block_b  = 8'h00;
		end else if (s.block_v && !s.in_block && s.block_b == CH_SLASH && c == CH_STAR) begin
			s.in_block = 1'b1;
			s.block_v  = 1'b0;
			s.block_b  = 8'h00;
		end else begin
			if (s.block_v && !s.in_block) begin
				s = line_push(s, s.block_b);
			end
			s.block_b = c;
			s.block_v = 1'b1;
		end
		return s;
	endfunction

	// Splice filter: drops backslash-newline pairs
	function automatic filt_t splice_push(filt_t s_in, logic [7:0] c);
		filt_t s;
		s = s_in;
		s.emit_v = 1'b0;
		s.emit_b = 8'h00;
		if (s.splice_v && s.splice_b == CH_BACKSLASH && c == CH_NEWLINE) begin
			s.splice_v = 1'b0;
			s.splice_b = 8'h00;
		end else begin
			if (s.splice_v) begin
				s = block_push(s, s.splice_b);
			end
			s.splice_b = c;
			s.splice_v = 1'b1;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

### src/ccs_front.sv
// Front end: runs the three filters on each accepted item and queues its result slots.
`default_nettype none
module ccs_front
	import ccs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,   // item taken this cycle
	input  wire logic [7:0] in_byte,
	input  wire logic       is_final,
	output qent_t           ent       // result slots of the current item
);

	filt_t state_q;
	filt_t s1;
	filt_t s2;
	filt_t s3;

	// Filter chain for one byte, then the flush sequence on the final byte
	always_comb begin
		s1 = splice_push(state_q, in_byte);
		s2 = s1;
		s2.emit_v = 1'b0;
		s2.emit_b = 8'h00;
		if (s1.splice_v) begin
			s2 = block_push(s1, s1.splice_b);
		end
		s3 = s2;
		s3.emit_v = 1'b0;
		s3.emit_b = 8'h00;
		if (s2.block_v && !s2.in_block) begin
			s3 = line_push(s2, s2.block_b);
		end
	end

	// Slot order matches emit order: new byte, splice flush, block flush, line flush
	always_comb begin
		ent.fin      = is_final;
		ent.mask[0]  = s1.emit_v;
		ent.bytes[0] = s1.emit_b;
		ent.mask[1]  = is_final && s2.emit_v;
		ent.bytes[1] = s2.emit_b;
		ent.mask[2]  = is_final && s3.emit_v;
		ent.bytes[2] = s3.emit_b;
		ent.mask[3]  = is_final && s3.line_v;
		ent.bytes[3] = s3.line_b;
	end

	// Filter state; a final item returns it to reset for the next text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			if (is_final) begin
				state_q <= '0;
			end else begin
				state_q <= s1;
			end
		end
	end

endmodule
`default_nettype wire

### src/ccs_queue.sv
// Short FIFO of result-slot entries between front and back.
`default_nettype none
module ccs_queue
	import ccs_pkg::*;
#(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t push_ent,
	output logic       full,
	input  wire logic  pop,
	output qhead_t     head
);

	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	qent_t            mem_q [QueueDepth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full       = (count_q == CntW'(QueueDepth));
	assign head.valid = (count_q != '0);
	assign head.ent   = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == PtrW'(QueueDepth - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == PtrW'(QueueDepth - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### src/ccs_back.sv
// Back end: walks the slots of the queue head and drives the output register.
`default_nettype none
module ccs_back
	import ccs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire qhead_t     head,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            has_byte,
	output logic            end_of_text
);

	logic [SLOTS-1:0]  done_q;
	logic [SLOTS-1:0]  remaining;
	logic [SLOTS-1:0]  low_bit;
	logic [SLOT_W-1:0] low_idx;
	logic              only_one;
	logic              load_ok;

	logic              valid_q;
	logic [7:0]        byte_q;
	logic              has_q;
	logic              last_q;

	// Pick the lowest slot still to be sent
	always_comb begin
		remaining = head.ent.mask & ~done_q;
		low_bit   = remaining & (~remaining + 1'b1);
		only_one  = ((remaining & (remaining - 1'b1)) == '0);
		low_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (remaining[i]) begin
				low_idx = SLOT_W'(i);
			end
		end
	end

	assign load_ok = !valid_q || out_ready;
	assign pop     = head.valid && load_ok && only_one;

	// Output register and per-entry progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			byte_q  <= 8'h00;
			has_q   <= 1'b0;
			last_q  <= 1'b0;
			done_q  <= '0;
		end else if (load_ok) begin
			if (head.valid && remaining == '0) begin
				// nothing kept: only a final item yields an empty end marker
				valid_q <= head.ent.fin;
				byte_q  <= 8'h00;
				has_q   <= 1'b0;
				last_q  <= 1'b1;
				done_q  <= '0;
			end else if (head.valid) begin
				valid_q <= 1'b1;
				byte_q  <= head.ent.bytes[low_idx];
				has_q   <= 1'b1;
				last_q  <= head.ent.fin && only_one;
				if (only_one) begin
					done_q <= '0;
				end else begin
					done_q <= done_q | low_bit;
				end
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign has_byte    = has_q;
	assign end_of_text = last_q;

endmodule
`default_nettype wire

### src/c_comment_and_splice_stripper_top.sv
// Top level of the C comment and line-splice stripper.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata[7:0]=in_byte, tlast=is_final
//  m_*       out  m_tvalid/m_tready  tdata[7:0]=out_byte, tuser=has_byte, tlast=end_of_text
//
// One byte is taken per cycle while the queue has room; the filters finish it in
// the cycle of acceptance. A non-final byte yields zero or one result; a final
// byte yields one to four results, one per cycle while m_tready holds. The results
// of a byte pass through the queue and then the back end's output register.
// s_tready drops only when the QueueDepth-entry queue is full.
// arst_n clears the filter state, the queue and the output register.
`default_nettype none
module c_comment_and_splice_stripper_top
	import ccs_pkg::*;
#(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tuser,   // [0] has_byte
	output logic            m_tlast
);

	logic   accept;
	logic   q_full;
	logic   q_pop;
	qent_t  front_ent;
	qhead_t q_head;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	ccs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (s_tdata),
		.is_final (s_tlast),
		.ent      (front_ent)
	);

	ccs_queue #(
		.QueueDepth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_ent (front_ent),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head)
	);

	ccs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.has_byte    (m_tuser),
		.end_of_text (m_tlast)
	);

`ifndef SYNTHESIS
	// An empty result is only ever the end marker of a text
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata == 8'h00)
		else $error("empty result without end of text");

	// Backpressure on the input only comes with entries waiting in the queue
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_head.valid)
		else $error("input stalled with empty queue");

	// A pop only happens on a valid queue head
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head.valid)
		else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

### verif/tb_c_comment_and_splice_stripper_top.sv
// Testbench for the C comment and line-splice stripper: directed and random texts, self-checked.
module tb_c_comment_and_splice_stripper_top;
	import ccs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT    = 2000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 12;
	localparam int MAX_REPORTS    = 10;

	// One output item as the checker sees it
	typedef struct packed {
		logic [7:0] ch;
		logic       has;
		logic       eot;
	} out_char_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
	logic       s_tlast  = 1'b0;    // is_final
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] out_byte
	logic       m_tuser;            // [0] has_byte
	logic       m_tlast;            // end_of_text

	c_comment_and_splice_stripper_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted stripper state: splice, block and line lookahead
	logic [7:0] sp_byte, bk_byte, ln_byte;
	logic       sp_full = 1'b0, bk_full = 1'b0, ln_full = 1'b0;
	logic       in_blk = 1'b0, in_line_cmt = 1'b0;

	out_char_t  step_chars[$];
	out_char_t  expected_chars[$];

	int bytes_sent   = 0;
	int texts_done   = 0;
	int results_seen = 0;
	int mismatches   = 0;

	// Sender pacing
	int burst_left  = 0;
	bit src_gaps_on = 1'b1;

	// Receiver control: free-running ready, and long hold-off requests
	bit rx_free         = 1'b0;
	int holdoff_asked   = 0;
	int holdoff_served  = 0;
	int hold_cnt        = 0;
	int rx_tick         = 0;
	logic [15:0] rx_pattern = 16'hFFFF;

	int idle_cycles = 0;

	task automatic keep_char(input logic [7:0] c);
		out_char_t r;
		r.ch  = c;
		r.has = 1'b1;
		r.eot = 1'b0;
		step_chars.push_back(r);
	endtask

	// Line comment stage: drop from double slash up to the newline
	task automatic line_take(input logic [7:0] c);
		if (in_line_cmt) begin
			if (c == CH_NEWLINE) begin
				in_line_cmt = 1'b0;
				ln_byte     = c;
				ln_full     = 1'b1;
			end
		end else if (ln_full && ln_byte == CH_SLASH && c == CH_SLASH) begin
			in_line_cmt = 1'b1;
			ln_full     = 1'b0;
		end else begin
			if (ln_full)
				keep_char(ln_byte);
			ln_byte = c;
			ln_full = 1'b1;
		end
	endtask

	// Block comment stage: drop slash-star through star-slash
	task automatic block_take(input logic [7:0] c);
		if (bk_full && in_blk && bk_byte == CH_STAR && c == CH_SLASH) begin
			in_blk  = 1'b0;
			bk_full = 1'b0;
		end else if (bk_full && !in_blk && bk_byte == CH_SLASH && c == CH_STAR) begin
			in_blk  = 1'b1;
			bk_full = 1'b0;
		end else begin
			if (bk_full && !in_blk)
				line_take(bk_byte);
			bk_byte = c;
			bk_full = 1'b1;
		end
	endtask

	// Splice stage: drop backslash-newline
	task automatic splice_take(input logic [7:0] c);
		if (sp_full && sp_byte == CH_BACKSLASH && c == CH_NEWLINE) begin
			sp_full = 1'b0;
		end else begin
			if (sp_full)
				block_take(sp_byte);
			sp_byte = c;
			sp_full = 1'b1;
		end
	endtask

	// Work out the output items of one accepted byte and queue them
	task automatic predict_stripped(input logic [7:0] c, input logic fin);
		out_char_t r;
		step_chars.delete();
		splice_take(c);
		if (fin) begin
			if (sp_full)
				block_take(sp_byte);
			if (bk_full && !in_blk)
				line_take(bk_byte);
			if (ln_full)
				keep_char(ln_byte);
			if (step_chars.size() == 0) begin
				r.ch  = 8'h00;
				r.has = 1'b0;
				r.eot = 1'b1;
				step_chars.push_back(r);
			end else begin
				step_chars[step_chars.size()-1].eot = 1'b1;
			end
			sp_full     = 1'b0;
			bk_full     = 1'b0;
			ln_full     = 1'b0;
			in_blk      = 1'b0;
			in_line_cmt = 1'b0;
		end
		foreach (step_chars[i])
			expected_chars.push_back(step_chars[i]);
	endtask

	// Offer one byte, honoring bursts and gaps; predict once it is taken
	task automatic send_byte(input logic [7:0] c, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = src_gaps_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		predict_stripped(c, fin);
		bytes_sent++;
		if (fin)
			texts_done++;
	endtask

	task automatic send_text(input string txt, input logic fin);
		for (int i = 0; i < txt.len(); i++)
			send_byte(txt[i], fin && (i == txt.len() - 1));
	endtask

	// Mostly letters, with the marker characters mixed in
	function automatic logic [7:0] filler_char();
		case ($urandom_range(0, 11))
			0: return CH_BACKSLASH;
			1: return CH_NEWLINE;
			2: return CH_SLASH;
			3: return CH_STAR;
			4: return 8'($urandom_range(0, 255));
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// Random texts built from comments, splices and plain runs, each ending final
	task automatic send_random_texts(input int n_bytes);
		logic [7:0] txt[$];
		int len, k;
		while (n_bytes > 0) begin
			len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 4) : $urandom_range(5, 40);
			if (len > n_bytes)
				len = n_bytes;
			txt.delete();
			while (txt.size() < len) begin
				k = $urandom_range(0, 6);
				case ($urandom_range(0, 9))
					0, 1: begin
						txt.push_back(CH_SLASH);
						txt.push_back(CH_STAR);
						repeat (k) txt.push_back(filler_char());
						if ($urandom_range(0, 4) != 0) begin
							txt.push_back(CH_STAR);
							txt.push_back(CH_SLASH);
						end
					end
					2, 3: begin
						txt.push_back(CH_SLASH);
						txt.push_back(CH_SLASH);
						repeat (k) txt.push_back(filler_char());
						txt.push_back(CH_NEWLINE);
					end
					4: begin
						txt.push_back(CH_BACKSLASH);
						txt.push_back(CH_NEWLINE);
					end
					5: begin
						txt.push_back(CH_STAR);
						txt.push_back(CH_SLASH);
					end
					9: txt.push_back(8'($urandom_range(0, 255)));
					default: repeat (k + 1) txt.push_back(filler_char());
				endcase
			end
			// truncation leaves broken comments at the end of some texts
			while (txt.size() > len)
				void'(txt.pop_back());
			foreach (txt[i])
				send_byte(txt[i], i == len - 1);
			n_bytes -= len;
		end
	endtask

	// Splices, comment corners, extremes and end-of-text flushes
	task automatic test_directed_cases();
		src_gaps_on = 1'b1;
		rx_free     = 1'b0;
		send_text("x\\\n*/", 1'b0);   // splice, then stray star-slash
		send_text("/*/*/", 1'b0);     // slash-star-slash does not close
		send_text("//\nk", 1'b0);     // empty line comment keeps next line
		send_text("//z\n", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_text("\\", 1'b1);        // trailing backslash kept
		send_text("/*", 1'b1);        // open block at end, nothing kept
		send_text("//q", 1'b1);       // open line comment at end
	endtask

	task automatic test_random_texts();
		src_gaps_on = 1'b1;
		rx_free     = 1'b0;
		send_random_texts(220);
	endtask

	// Receiver holds off while the sender keeps offering: input must stall
	task automatic test_output_holdoff();
		src_gaps_on = 1'b0;
		rx_free     = 1'b0;
		holdoff_asked++;
		send_random_texts(80);
	endtask

	task automatic test_full_rate();
		src_gaps_on = 1'b0;
		rx_free     = 1'b1;
		send_random_texts(90);
	endtask

	// Receiver ready: hold-off stretches, free-running if rx_free, else a random pattern
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (hold_cnt != 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
			if (hold_cnt == 1)
				holdoff_served <= holdoff_served + 1;
		end else if (holdoff_asked != holdoff_served) begin
			m_tready <= 1'b0;
			hold_cnt <= HOLDOFF_CYCLES;
		end else if (rx_free) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= rx_pattern[rx_tick % 16];
		end
		if (rx_tick % 64 == 63) begin
			case ($urandom_range(0, 3))
				0: rx_pattern <= 16'hFFFF;
				1: rx_pattern <= 16'($urandom);
				2: rx_pattern <= 16'($urandom) | 16'($urandom);
				default: rx_pattern <= 16'($urandom) & 16'($urandom);
			endcase
		end
	end

	// Compare each output item with the oldest prediction
	always @(posedge clk) begin : check_out
		out_char_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.ch  = m_tdata;
			got.has = m_tuser;
			got.eot = m_tlast;
			results_seen++;
			if (expected_chars.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: unexpected item byte %02h has %0b end %0b",
						$time, got.ch, got.has, got.eot);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				if (got != want) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: expected byte %02h has %0b end %0b, got byte %02h has %0b end %0b",
							$time, want.ch, want.has, want.eot, got.ch, got.has, got.eot);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_texts();
		test_output_holdoff();
		test_full_rate();
		s_tvalid <= 1'b0;

		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_chars.size() != 0)
			mismatches++;
		$display("Stripped %0d bytes in %0d texts, checked %0d output items", bytes_sent,
			texts_done, results_seen);
		$display("Covered splices, open and closed comments, end flushes, gaps and a long output stall");
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
